FILE: sv/line_window_clipper_assert.svh
// Assertion macros for the line window clipper checker
`ifndef LINE_WINDOW_CLIPPER_ASSERT_SVH
`define LINE_WINDOW_CLIPPER_ASSERT_SVH

// same-cycle implication, disabled in reset
`define LWC_ASSERT_IMPLY(label, clk, rst, lhs, rhs) \
  label: assert property (@(posedge clk) disable iff (rst) (lhs) |-> (rhs)) \
    else $error("line_window_clipper: assertion failed");

// next-cycle implication, disabled in reset
`define LWC_ASSERT_NEXT(label, clk, rst, lhs, rhs) \
  label: assert property (@(posedge clk) disable iff (rst) (lhs) |=> (rhs)) \
    else $error("line_window_clipper: assertion failed");

`endif

FILE: sv/lwc_pkg.sv
// Shared types and constants for the line window clipper
`default_nettype none
package lwc_pkg;
  localparam int WIN_WIDTH = 19;
  localparam int MAX_FIXES = 8;
  localparam int FIX_CNT_WIDTH = 4;
  localparam int CFG_INDEX_WIDTH = 2;

  localparam logic [CFG_INDEX_WIDTH-1:0] REG_LEFT   = 2'd0;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_TOP    = 2'd1;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_RIGHT  = 2'd2;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_BOTTOM = 2'd3;

  localparam logic [WIN_WIDTH-1:0] RST_LEFT   = 19'd0;
  localparam logic [WIN_WIDTH-1:0] RST_TOP    = 19'd0;
  localparam logic [WIN_WIDTH-1:0] RST_RIGHT  = 19'd262144;
  localparam logic [WIN_WIDTH-1:0] RST_BOTTOM = 19'd262144;

  localparam int OC_BELOW_BOTTOM = 0;
  localparam int OC_ABOVE_TOP    = 1;
  localparam int OC_RIGHT        = 2;
  localparam int OC_LEFT         = 3;

  typedef struct packed {
    logic [WIN_WIDTH-1:0] left;
    logic [WIN_WIDTH-1:0] top;
    logic [WIN_WIDTH-1:0] right;
    logic [WIN_WIDTH-1:0] bottom;
  } window_t;
endpackage
`default_nettype wire

FILE: sv/line_window_clipper.sv
// Top level of the line window clipper
//
//   channel  | dir | handshake                     | payload
//   s_axis   | in  | s_axis_tvalid/s_axis_tready   | one segment, two endpoints
//   m_axis   | out | m_axis_tvalid/m_axis_tready   | clipped segment, reject flag
//   cfg      | in  | cfg_valid/cfg_ready           | window register write
//
// A segment takes from 0 to 8 endpoint moves; each move is a bit-serial multiply
// then a bit-serial divide, on coordinates widened to max(COORD_WIDTH, 20) bits.
// The engine works one segment at a time; a two-entry queue takes new segments
// meanwhile and the output register holds a result until transferred.
// Reset is synchronous and sets the window to its defaults; config is always ready.
`default_nettype none
module line_window_clipper #(
  parameter int COORD_WIDTH = 20
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               s_axis_tvalid,
  output logic                                    s_axis_tready,
  // start_x, start_y, end_x, end_y
  input  wire logic [((4*COORD_WIDTH+7)/8)*8-1:0] s_axis_tdata,
  output logic                                    m_axis_tvalid,
  input  wire logic                               m_axis_tready,
  // clipped_start_x, clipped_start_y, clipped_end_x, clipped_end_y
  output logic [((4*COORD_WIDTH+7)/8)*8-1:0]      m_axis_tdata,
  // rejected
  output logic                                    m_axis_tuser,
  input  wire logic                               cfg_valid,
  output logic                                    cfg_ready,
  input  wire logic [lwc_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
  input  wire logic [lwc_pkg::WIN_WIDTH-1:0]      cfg_data
);
  localparam int IW_ITEM = 4 * COORD_WIDTH;
  localparam int TW      = ((4 * COORD_WIDTH + 7) / 8) * 8;

  lwc_pkg::window_t      win;
  logic                  q_valid;
  logic                  q_ready;
  logic [IW_ITEM-1:0]    q_item;
  logic [IW_ITEM-1:0]    out_coords;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      win.left   <= lwc_pkg::RST_LEFT;
      win.top    <= lwc_pkg::RST_TOP;
      win.right  <= lwc_pkg::RST_RIGHT;
      win.bottom <= lwc_pkg::RST_BOTTOM;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        lwc_pkg::REG_LEFT:   win.left   <= cfg_data;
        lwc_pkg::REG_TOP:    win.top    <= cfg_data;
        lwc_pkg::REG_RIGHT:  win.right  <= cfg_data;
        lwc_pkg::REG_BOTTOM: win.bottom <= cfg_data;
        default:             win        <= win;
      endcase
    end
  end

  lwc_front #(
    .ITEM_WIDTH(IW_ITEM)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .in_item  (s_axis_tdata[IW_ITEM-1:0]),
    .q_valid  (q_valid),
    .q_ready  (q_ready),
    .q_item   (q_item)
  );

  lwc_back #(
    .COORD_WIDTH(COORD_WIDTH)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .win          (win),
    .q_valid      (q_valid),
    .q_ready      (q_ready),
    .q_item       (q_item),
    .out_valid    (m_axis_tvalid),
    .out_ready    (m_axis_tready),
    .out_rejected (m_axis_tuser),
    .out_coords   (out_coords)
  );

  assign m_axis_tdata = TW'(out_coords);
endmodule
`default_nettype wire

FILE: sv/lwc_front.sv
// Front end: accepts segments into a two-entry queue for the clip engine
`default_nettype none
module lwc_front #(
  parameter int ITEM_WIDTH = 80
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic [ITEM_WIDTH-1:0] in_item,
  output logic                       q_valid,
  input  wire logic                  q_ready,
  output logic [ITEM_WIDTH-1:0]      q_item
);
  logic [ITEM_WIDTH-1:0] entries [2];
  logic                  wptr;
  logic                  rptr;
  logic [1:0]            count;
  logic                  push;
  logic                  pop;

  assign in_ready = (count != 2'd2);
  assign q_valid  = (count != 2'd0);
  assign q_item   = entries[rptr];
  assign push     = in_valid && in_ready;
  assign pop      = q_valid && q_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wptr] <= in_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) begin
        wptr <= ~wptr;
      end
      if (pop) begin
        rptr <= ~rptr;
      end
      unique case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end
endmodule
`default_nettype wire

FILE: sv/lwc_back.sv
// Clip engine: outcode test, serial multiply and divide, endpoint move
`default_nettype none
module lwc_back #(
  parameter int COORD_WIDTH = 20
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire lwc_pkg::window_t         win,
  input  wire logic                     q_valid,
  output logic                          q_ready,
  input  wire logic [4*COORD_WIDTH-1:0] q_item,
  output logic                          out_valid,
  input  wire logic                     out_ready,
  output logic                          out_rejected,
  output logic [4*COORD_WIDTH-1:0]      out_coords
);
  localparam int IW   = (COORD_WIDTH > 20) ? COORD_WIDTH : 20;
  localparam int DW   = IW + 1;
  localparam int PW   = 2 * DW;
  localparam int CNTW = $clog2(PW + 1);
  localparam int WW   = lwc_pkg::WIN_WIDTH;

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_DECIDE = 3'd1;
  localparam logic [2:0] ST_MUL    = 3'd2;
  localparam logic [2:0] ST_DIV    = 3'd3;
  localparam logic [2:0] ST_FIX    = 3'd4;
  localparam logic [2:0] ST_DONE   = 3'd5;

  logic [2:0]                        state;
  logic signed [IW-1:0]              sx, sy, ex, ey;
  logic [lwc_pkg::FIX_CNT_WIDTH-1:0] fixes;
  logic [CNTW-1:0]                   cnt;
  logic [DW-1:0]                     ua, ub, uc, q;
  logic [PW-1:0]                     prod;
  logic [DW-1:0]                     rem;
  logic                              neg, yedge, mover, rej;
  logic signed [IW-1:0]              edge_val;

  function automatic logic signed [IW-1:0] win_ext(input logic [WW-1:0] v);
    win_ext = $signed({{(IW-WW){1'b0}}, v});
  endfunction

  function automatic logic [3:0] outcode(input logic signed [IW-1:0] x,
                                         input logic signed [IW-1:0] y,
                                         input lwc_pkg::window_t w);
    logic [3:0] c;
    c = 4'd0;
    c[lwc_pkg::OC_BELOW_BOTTOM] = (y > win_ext(w.bottom));
    c[lwc_pkg::OC_ABOVE_TOP]    = (y < win_ext(w.top));
    c[lwc_pkg::OC_RIGHT]        = (x > win_ext(w.right));
    c[lwc_pkg::OC_LEFT]         = (x < win_ext(w.left));
    outcode = c;
  endfunction

  function automatic logic signed [DW-1:0] ext(input logic signed [IW-1:0] v);
    ext = $signed({v[IW-1], v});
  endfunction

  function automatic logic [DW-1:0] mag(input logic signed [DW-1:0] v);
    mag = v[DW-1] ? DW'(-v) : DW'(v);
  endfunction

  logic [3:0]           c0, c1, code;
  logic                 dec_y;
  logic signed [IW-1:0] dec_edge;
  logic signed [DW-1:0] da, db, dc;
  logic [DW:0]          rs;
  logic                 rs_ge;
  logic signed [DW-1:0] qs;
  logic signed [IW-1:0] base, moved;

  always_comb begin
    c0    = outcode(sx, sy, win);
    c1    = outcode(ex, ey, win);
    code  = (c0 != 4'd0) ? c0 : c1;
    dec_y = code[lwc_pkg::OC_BELOW_BOTTOM] || code[lwc_pkg::OC_ABOVE_TOP];
    priority if (code[lwc_pkg::OC_BELOW_BOTTOM]) begin
      dec_edge = win_ext(win.bottom);
    end else if (code[lwc_pkg::OC_ABOVE_TOP]) begin
      dec_edge = win_ext(win.top);
    end else if (code[lwc_pkg::OC_RIGHT]) begin
      dec_edge = win_ext(win.right);
    end else begin
      dec_edge = win_ext(win.left);
    end
    if (dec_y) begin
      da = ext(ex) - ext(sx);
      db = ext(dec_edge) - ext(sy);
      dc = ext(ey) - ext(sy);
    end else begin
      da = ext(ey) - ext(sy);
      db = ext(dec_edge) - ext(sx);
      dc = ext(ex) - ext(sx);
    end
    rs    = {rem, prod[PW-1]};
    rs_ge = (rs >= {1'b0, uc});
    qs    = (uc == '0) ? '0 : (neg ? DW'(-$signed(q)) : $signed(q));
    base  = yedge ? sx : sy;
    moved = IW'(ext(base) + qs);
  end

  assign q_ready = (state == ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready && (state != ST_DONE)) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (q_valid) begin
            sx    <= IW'($signed(q_item[COORD_WIDTH-1:0]));
            sy    <= IW'($signed(q_item[2*COORD_WIDTH-1:COORD_WIDTH]));
            ex    <= IW'($signed(q_item[3*COORD_WIDTH-1:2*COORD_WIDTH]));
            ey    <= IW'($signed(q_item[4*COORD_WIDTH-1:3*COORD_WIDTH]));
            fixes <= '0;
            state <= ST_DECIDE;
          end
        end
        ST_DECIDE: begin
          priority if ((c0 | c1) == 4'd0) begin
            rej   <= 1'b0;
            state <= ST_DONE;
          end else if ((c0 & c1) != 4'd0) begin
            rej   <= 1'b1;
            state <= ST_DONE;
          end else if (fixes == lwc_pkg::FIX_CNT_WIDTH'(lwc_pkg::MAX_FIXES)) begin
            rej   <= 1'b1;
            state <= ST_DONE;
          end else begin
            ua       <= mag(da);
            ub       <= mag(db);
            uc       <= mag(dc);
            neg      <= da[DW-1] ^ db[DW-1] ^ dc[DW-1];
            yedge    <= dec_y;
            mover    <= (c0 != 4'd0);
            edge_val <= dec_edge;
            prod     <= '0;
            cnt      <= '0;
            state    <= ST_MUL;
          end
        end
        ST_MUL: begin
          prod <= (prod << 1) + (ub[DW-1] ? PW'(ua) : '0);
          ub   <= ub << 1;
          if (cnt == CNTW'(DW - 1)) begin
            cnt   <= '0;
            rem   <= '0;
            q     <= '0;
            state <= ST_DIV;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        ST_DIV: begin
          prod <= prod << 1;
          if (rs_ge) begin
            rem <= DW'(rs - {1'b0, uc});
          end else begin
            rem <= DW'(rs);
          end
          q <= {q[DW-2:0], rs_ge};
          if (cnt == CNTW'(PW - 1)) begin
            state <= ST_FIX;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        ST_FIX: begin
          if (mover) begin
            sx <= yedge ? moved : edge_val;
            sy <= yedge ? edge_val : moved;
          end else begin
            ex <= yedge ? moved : edge_val;
            ey <= yedge ? edge_val : moved;
          end
          fixes <= fixes + 1'b1;
          state <= ST_DECIDE;
        end
        ST_DONE: begin
          if (!out_valid || out_ready) begin
            out_valid    <= 1'b1;
            out_rejected <= rej;
            out_coords   <= {ey[COORD_WIDTH-1:0], ex[COORD_WIDTH-1:0],
                             sy[COORD_WIDTH-1:0], sx[COORD_WIDTH-1:0]};
            state        <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

FILE: sv/lwc_checker.sv
// Port-level checker for the line window clipper, bound to the top level
`default_nettype none
`include "line_window_clipper_assert.svh"
module lwc_checker (
  input wire logic clk,
  input wire logic rst,
  input wire logic m_axis_tvalid,
  input wire logic m_axis_tready,
  input wire logic m_axis_tuser,
  input wire logic cfg_valid,
  input wire logic cfg_ready
);
  `LWC_ASSERT_NEXT(a_out_hold, clk, rst, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)
  `LWC_ASSERT_IMPLY(a_cfg_ready, clk, rst, cfg_valid, cfg_ready)
  `LWC_ASSERT_NEXT(a_flag_hold, clk, rst, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tuser))
endmodule

bind line_window_clipper lwc_checker u_lwc_checker (
  .clk           (clk),
  .rst           (rst),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tuser  (m_axis_tuser),
  .cfg_valid     (cfg_valid),
  .cfg_ready     (cfg_ready)
);
`default_nettype wire

FILE: verif/line_window_clipper_checker.sv
// Checker for the line window clipper: watches the channels, predicts the clipped segment
`timescale 1ns / 100ps
`default_nettype none
module line_window_clipper_checker (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            s_axis_tvalid,
  input  wire logic                            s_axis_tready,
  input  wire logic [79:0]                     s_axis_tdata,
  input  wire logic                            m_axis_tvalid,
  input  wire logic                            m_axis_tready,
  input  wire logic [79:0]                     m_axis_tdata,
  input  wire logic                            m_axis_tuser,
  input  wire logic                            cfg_valid,
  input  wire logic                            cfg_ready,
  input  wire logic [lwc_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
  input  wire logic [lwc_pkg::WIN_WIDTH-1:0]   cfg_data,
  output int                                   fail_count,
  output int                                   pending,
  output int                                   clip_count,
  output int                                   reject_count
);
  typedef struct packed {
    logic        rejected;
    logic [19:0] ey;
    logic [19:0] ex;
    logic [19:0] sy;
    logic [19:0] sx;
  } clip_result_t;

  lwc_pkg::window_t win;
  clip_result_t clip_queue[$];

  function automatic longint quot_trunc(longint a, longint b, longint c);
    longint p;
    if (c == 0) return 0;
    p = a * b;
    return p / c;
  endfunction

  function automatic logic [3:0] region(lwc_pkg::window_t w, longint x, longint y);
    logic [3:0] c;
    c = '0;
    c[lwc_pkg::OC_BELOW_BOTTOM] = y > longint'(w.bottom);
    c[lwc_pkg::OC_ABOVE_TOP]    = y < longint'(w.top);
    c[lwc_pkg::OC_RIGHT]        = x > longint'(w.right);
    c[lwc_pkg::OC_LEFT]         = x < longint'(w.left);
    return c;
  endfunction

  function automatic clip_result_t clip_segment(lwc_pkg::window_t w, logic [79:0] d);
    longint sx, sy, ex, ey, x, y;
    logic [3:0] c0, c1, code;
    clip_result_t r;
    logic rej;
    sx = longint'($signed(d[19:0]));
    sy = longint'($signed(d[39:20]));
    ex = longint'($signed(d[59:40]));
    ey = longint'($signed(d[79:60]));
    rej = 1'b1;
    for (int n = 0; n <= lwc_pkg::MAX_FIXES; n++) begin
      c0 = region(w, sx, sy);
      c1 = region(w, ex, ey);
      if ((c0 | c1) == 0) begin
        rej = 1'b0;
        break;
      end
      if ((c0 & c1) != 0 || n == lwc_pkg::MAX_FIXES) break;
      code = (c0 != 0) ? c0 : c1;
      if (code[lwc_pkg::OC_BELOW_BOTTOM] || code[lwc_pkg::OC_ABOVE_TOP]) begin
        y = code[lwc_pkg::OC_BELOW_BOTTOM] ? longint'(w.bottom) : longint'(w.top);
        x = sx + quot_trunc(ex - sx, y - sy, ey - sy);
      end else begin
        x = code[lwc_pkg::OC_RIGHT] ? longint'(w.right) : longint'(w.left);
        y = sy + quot_trunc(ey - sy, x - sx, ex - sx);
      end
      if (c0 != 0) begin
        sx = x;
        sy = y;
      end else begin
        ex = x;
        ey = y;
      end
    end
    r.rejected = rej;
    r.sx = sx[19:0];
    r.sy = sy[19:0];
    r.ex = ex[19:0];
    r.ey = ey[19:0];
    return r;
  endfunction

  always @(posedge clk) begin
    clip_result_t want, got;
    if (rst) begin
      win <= '{left: lwc_pkg::RST_LEFT, top: lwc_pkg::RST_TOP,
               right: lwc_pkg::RST_RIGHT, bottom: lwc_pkg::RST_BOTTOM};
      clip_queue.delete();
      pending <= 0;
      fail_count <= 0;
      clip_count <= 0;
      reject_count <= 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          lwc_pkg::REG_LEFT: begin
            win.left <= cfg_data;
          end
          lwc_pkg::REG_TOP: begin
            win.top <= cfg_data;
          end
          lwc_pkg::REG_RIGHT: begin
            win.right <= cfg_data;
          end
          default: begin
            win.bottom <= cfg_data;
          end
        endcase
      end
      if (s_axis_tvalid && s_axis_tready) clip_queue.push_back(clip_segment(win, s_axis_tdata));
      if (m_axis_tvalid && m_axis_tready) begin
        got = {m_axis_tuser, m_axis_tdata};
        clip_count <= clip_count + 1;
        if (clip_queue.size() == 0) begin
          $error("unexpected result transfer");
          fail_count <= fail_count + 1;
        end else begin
          want = clip_queue.pop_front();
          reject_count <= reject_count + want.rejected;
          if (got != want) begin
            fail_count <= fail_count + 1;
            if (got.rejected != want.rejected)
              $error("rejected: expected %0d actual %0d", want.rejected, got.rejected);
            if (got.sx != want.sx)
              $error("clipped_start_x: expected %0d actual %0d", $signed(want.sx), $signed(got.sx));
            if (got.sy != want.sy)
              $error("clipped_start_y: expected %0d actual %0d", $signed(want.sy), $signed(got.sy));
            if (got.ex != want.ex)
              $error("clipped_end_x: expected %0d actual %0d", $signed(want.ex), $signed(got.ex));
            if (got.ey != want.ey)
              $error("clipped_end_y: expected %0d actual %0d", $signed(want.ey), $signed(got.ey));
          end
        end
      end
      pending <= clip_queue.size();
    end
  end
endmodule
`default_nettype wire

FILE: verif/line_window_clipper_tb.sv
// Stimulus and verdict for the line window clipper
`timescale 1ns / 100ps
`default_nettype none
module line_window_clipper_tb;
  localparam int LIMIT_CYCLES = 2000000;
  localparam int DRAIN_CYCLES = 600;

  logic clk, rst;
  logic s_axis_tvalid, s_axis_tready, m_axis_tvalid, m_axis_tready, m_axis_tuser;
  logic [79:0] s_axis_tdata, m_axis_tdata;
  logic cfg_valid, cfg_ready;
  logic [lwc_pkg::CFG_INDEX_WIDTH-1:0] cfg_index;
  logic [lwc_pkg::WIN_WIDTH-1:0] cfg_data;
  int fail_count, pending, clip_count, reject_count, cycle_count, hold_off;
  int segment_count;
  logic long_hold;

  line_window_clipper dut (.*);

  line_window_clipper_checker checker_i (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("line_window_clipper verification failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
      hold_off <= 0;
    end else if (long_hold) begin
      m_axis_tready <= 1'b0;
      hold_off <= 3000;
    end else if (hold_off > 0) begin
      m_axis_tready <= 1'b0;
      hold_off <= hold_off - 1;
    end else if (cycle_count % 4000 < 1500) begin
      m_axis_tready <= 1'b1;
    end else begin
      m_axis_tready <= ($urandom_range(0, 3) != 0);
    end
  end

  task automatic write_reg(logic [lwc_pkg::CFG_INDEX_WIDTH-1:0] idx,
                           logic [lwc_pkg::WIN_WIDTH-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic set_window(int l, int t, int r, int b);
    write_reg(lwc_pkg::REG_LEFT, l[lwc_pkg::WIN_WIDTH-1:0]);
    write_reg(lwc_pkg::REG_TOP, t[lwc_pkg::WIN_WIDTH-1:0]);
    write_reg(lwc_pkg::REG_RIGHT, r[lwc_pkg::WIN_WIDTH-1:0]);
    write_reg(lwc_pkg::REG_BOTTOM, b[lwc_pkg::WIN_WIDTH-1:0]);
    cfg_valid <= 1'b0;
  endtask

  task automatic send_segment(int sx, int sy, int ex, int ey);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {ey[19:0], ex[19:0], sy[19:0], sx[19:0]};
    do @(posedge clk); while (!s_axis_tready);
    segment_count++;
  endtask

  task automatic idle_gap();
    s_axis_tvalid <= 1'b0;
    repeat ($urandom_range(1, 40)) @(posedge clk);
  endtask

  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic int rand_coord(int l, int r);
    case ($urandom_range(0, 5))
      0: return $urandom_range(0, 1048575) - 524288;
      1: return $urandom_range(0, 1) ? 524287 : -524288;
      default: return $urandom_range(l, r + 1) + $urandom_range(0, 2000) - 1000;
    endcase
  endfunction

  task automatic random_phase(int count, int l, int t, int r, int b);
    int burst;
    burst = 0;
    repeat (count) begin
      if (burst == 0) begin
        idle_gap();
        burst = $urandom_range(1, 12);
      end
      send_segment(rand_coord(l, r), rand_coord(t, b), rand_coord(l, r), rand_coord(t, b));
      burst--;
    end
    settle();
  endtask

  initial begin
    rst = 1'b1;
    long_hold = 1'b0;
    cycle_count = 0;
    segment_count = 0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    cfg_valid = 1'b0;
    cfg_index = lwc_pkg::REG_LEFT;
    cfg_data = '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    set_window(1000, 2000, 50000, 60000);
    send_segment(5000, 5000, 6000, 7000);
    send_segment(-524288, 30000, 524287, 30000);
    send_segment(30000, -524288, 30000, 524287);
    send_segment(524287, 524287, -524288, -524288);
    send_segment(-524288, -524288, -524288, 524287);
    send_segment(0, 0, 0, 0);
    send_segment(100000, 5000, 100000, 9000);
    send_segment(500, 100, 70000, 80000);
    send_segment(1000, 2000, 50000, 60000);
    send_segment(999, 1999, 50001, 60001);
    send_segment(-1, 70000, 60000, -1);
    send_segment(40000, 61000, 60000, 40000);
    settle();

    set_window(0, 0, 0, 0);
    send_segment(-5, -5, 5, 5);
    send_segment(0, 0, 0, 0);
    send_segment(-100, 3, 100, -3);
    settle();

    set_window(262144, 262144, 262144, 262144);
    send_segment(524287, 262144, -524288, 262144);
    send_segment(300000, 200000, 200000, 300000);
    settle();

    set_window(40000, 40000, 10000, 10000);
    send_segment(0, 0, 50000, 50000);
    send_segment(-30000, 45000, 60000, 5000);
    settle();

    set_window(524287, 524287, 524287, 524287);
    send_segment(-524288, -524288, 524287, 524287);
    settle();

    set_window(0, 0, 262144, 262144);
    long_hold <= 1'b1;
    @(posedge clk);
    long_hold <= 1'b0;
    random_phase(300, 0, 0, 262144, 262144);

    set_window(20000, 5000, 120000, 70000);
    random_phase(300, 20000, 5000, 120000, 70000);

    set_window(0, 0, 524287, 524287);
    random_phase(150, 0, 0, 524287, 524287);

    set_window(1000, 1000, 1256, 1100);
    random_phase(150, 1000, 1000, 1256, 1100);

    $display("segments sent %0d, results checked %0d, rejected %0d",
             segment_count, clip_count, reject_count);
    $display("windows: default, narrow, degenerate, inverted, full range, edge cases");
    if (fail_count == 0 && pending == 0) begin
      $display("line_window_clipper verification clean");
    end else begin
      $display("line_window_clipper verification failed");
    end
    $finish;
  end
endmodule
`default_nettype wire
